FILE: hdl/ufhk_pkg.sv
// Shared types and constants for the hashed-key union-find engine.
// Used by ufhk_ctrl, ufhk_dpath and the union_find_hashed_keys top level.
`default_nettype none

package ufhk_pkg;

    // Table size must be a power of two (probe wraps by masking)
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 31;
    localparam int STEP_W      = 32;
    localparam int RANK_W      = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    typedef enum logic [1:0] {
        CMD_MAKE  = 2'd0,
        CMD_UNION = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_STEPS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WS_CUR = 2'd0,
        WS_SA  = 2'd1,
        WS_SB  = 2'd2
    } t_walk_src;

    typedef enum logic [0:0] {
        CFG_USE_RANK = 1'b0,
        CFG_USE_COMP = 1'b1
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      probe_next;
        logic      insert;
        logic      save_a;
        logic      save_b;
        logic      walk_start;
        t_walk_src walk_src;
        logic      walk_step;
        logic      walk_end;
        logic      walk_sel_y;
        logic      comp_start;
        logic      comp_step;
        logic      link;
        logic      use_rank;
        logic      respond;
        t_status   status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic used;
        logic hit;
        logic probe_last;
        logic is_root;
        logic walk_limit;
        logic at_root;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/ufhk_dpath.sv
// Datapath of the union-find engine: slot memories, probe and walk
// registers, step counter and result registers. Depends on ufhk_pkg.
`default_nettype none

module ufhk_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ufhk_pkg::t_dp_cmd          i_dp_cmd,
    output      ufhk_pkg::t_dp_stat         o_dp_stat,
    input  wire logic [1:0]                 i_cmd,
    input  wire logic [ufhk_pkg::KEY_W-1:0] i_key_a,
    input  wire logic [ufhk_pkg::KEY_W-1:0] i_key_b,
    output      logic [1:0]                 o_status,
    output      logic [ufhk_pkg::KEY_W-1:0] o_result_key,
    output      logic [ufhk_pkg::STEP_W-1:0] o_step_total
);
    import ufhk_pkg::*;

    // Slot memories and used bits
    logic [KEY_W-1:0]  r_key_mem  [TABLE_SLOTS];
    logic [SLOT_W-1:0] r_par_mem  [TABLE_SLOTS];
    logic [RANK_W-1:0] r_rank_mem [TABLE_SLOTS];
    logic              r_used     [TABLE_SLOTS];

    logic [KEY_W-1:0]  r_rd_key;
    logic [SLOT_W-1:0] r_rd_par;
    logic [RANK_W-1:0] r_rd_rank;
    logic              r_rd_used;

    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [SLOT_W-1:0] r_i;
    logic [CNT_W-1:0]  r_n;
    t_cmd              r_cmd;
    logic [KEY_W-1:0]  r_kb, r_target;
    logic [SLOT_W-1:0] r_sa, r_sb, r_start, r_root, r_rx, r_ry;
    logic [KEY_W-1:0]  r_key_x, r_key_y, r_res_key;
    logic [RANK_W-1:0] r_rank_x, r_rank_y;
    logic [STEP_W-1:0] r_step;
    logic [SLOT_W-1:0] walk_addr;

    logic              key_we, par_we, rank_we;
    logic [SLOT_W-1:0] par_wa, rank_wa;
    logic [SLOT_W-1:0] par_wd;
    logic [RANK_W-1:0] rank_wd;
    logic [KEY_W-1:0]  link_key;

    // Pick the start slot of a parent walk
    always_comb begin
        case (i_dp_cmd.walk_src)
            WS_SA:   walk_addr = r_sa;
            WS_SB:   walk_addr = r_sb;
            default: walk_addr = r_addr;
        endcase
    end

    // Next memory address; reads always follow it
    always_comb begin
        if (i_dp_cmd.load) begin
            n_addr = i_key_a[SLOT_W-1:0];
        end else if (i_dp_cmd.save_a) begin
            n_addr = r_kb[SLOT_W-1:0];
        end else if (i_dp_cmd.probe_next) begin
            n_addr = r_addr + r_i + SLOT_W'(1);
        end else if (i_dp_cmd.walk_start) begin
            n_addr = walk_addr;
        end else if (i_dp_cmd.walk_step || i_dp_cmd.comp_step) begin
            n_addr = r_rd_par;
        end else if (i_dp_cmd.comp_start) begin
            n_addr = r_start;
        end else begin
            n_addr = r_addr;
        end
    end

    // Write ports: insert, path compression and linking
    always_comb begin
        key_we   = i_dp_cmd.insert;
        par_we   = 1'b0;
        par_wa   = r_addr;
        par_wd   = r_addr;
        rank_we  = i_dp_cmd.insert;
        rank_wa  = r_addr;
        rank_wd  = '0;
        link_key = r_key_x;
        if (i_dp_cmd.insert) begin
            par_we = 1'b1;
        end else if (i_dp_cmd.comp_step) begin
            par_we = 1'b1;
            par_wd = r_root;
        end else if (i_dp_cmd.link && (r_rx != r_ry)) begin
            par_we = 1'b1;
            par_wa = r_ry;
            par_wd = r_rx;
            if (i_dp_cmd.use_rank) begin
                if (r_rank_x < r_rank_y) begin
                    par_wa   = r_rx;
                    par_wd   = r_ry;
                    link_key = r_key_y;
                end else if ((r_rank_x == r_rank_y) && (r_rank_x < RANK_MAX)) begin
                    rank_we = 1'b1;
                    rank_wa = r_rx;
                    rank_wd = r_rank_x + RANK_W'(1);
                end
            end
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_addr] <= r_target;
        end
        if (par_we) begin
            r_par_mem[par_wa] <= par_wd;
        end
        if (rank_we) begin
            r_rank_mem[rank_wa] <= rank_wd;
        end
        r_rd_key  <= r_key_mem[n_addr];
        r_rd_par  <= r_par_mem[n_addr];
        r_rd_rank <= r_rank_mem[n_addr];
        r_rd_used <= r_used[n_addr];
    end

    // Used bits clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                r_used[k] <= 1'b0;
            end
        end else if (i_dp_cmd.insert) begin
            r_used[r_addr] <= 1'b1;
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_dp_cmd.walk_step || i_dp_cmd.walk_end) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Probe, walk and link registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_dp_cmd.load) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_kb      <= i_key_b;
            r_target  <= i_key_a;
            r_i       <= '0;
            r_res_key <= '0;
        end
        if (i_dp_cmd.save_a) begin
            r_sa     <= r_addr;
            r_target <= r_kb;
            r_i      <= '0;
        end
        if (i_dp_cmd.probe_next) begin
            r_i <= r_i + SLOT_W'(1);
        end
        if (i_dp_cmd.insert) begin
            r_res_key <= r_target;
        end
        if (i_dp_cmd.save_b) begin
            r_sb <= r_addr;
        end
        if (i_dp_cmd.walk_start) begin
            r_start <= walk_addr;
            r_n     <= '0;
        end
        if (i_dp_cmd.comp_start) begin
            r_n <= '0;
        end
        if (i_dp_cmd.walk_step || i_dp_cmd.comp_step) begin
            r_n <= r_n + CNT_W'(1);
        end
        if (i_dp_cmd.walk_end) begin
            r_root <= r_addr;
            if (i_dp_cmd.walk_sel_y) begin
                r_ry     <= r_addr;
                r_key_y  <= r_rd_key;
                r_rank_y <= r_rd_rank;
            end else begin
                r_rx      <= r_addr;
                r_key_x   <= r_rd_key;
                r_rank_x  <= r_rd_rank;
                r_res_key <= r_rd_key;
            end
        end
        if (i_dp_cmd.link) begin
            r_res_key <= link_key;
        end
        if (i_dp_cmd.respond) begin
            o_status     <= i_dp_cmd.status;
            o_result_key <= r_res_key;
            o_step_total <= r_step;
        end
    end

    // Status back to the controller
    always_comb begin
        o_dp_stat.cmd        = r_cmd;
        o_dp_stat.used       = r_rd_used;
        o_dp_stat.hit        = r_rd_used && (r_rd_key == r_target);
        o_dp_stat.probe_last = (r_i == SLOT_W'(TABLE_SLOTS - 1));
        o_dp_stat.is_root    = (r_rd_par == r_addr);
        o_dp_stat.walk_limit = (r_n == CNT_W'(TABLE_SLOTS));
        o_dp_stat.at_root    = (r_addr == r_root);
    end

`ifndef SYNTHESIS
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.insert |-> !r_rd_used)
        else $error("insert into a used slot");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.walk_step || i_dp_cmd.comp_step) |-> (r_n < CNT_W'(TABLE_SLOTS)))
        else $error("walk counter past bound");
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.walk_step |=> r_step == $past(r_step) + STEP_W'(1))
        else $error("step counter missed a node");
`endif

endmodule

`default_nettype wire

FILE: hdl/ufhk_ctrl.sv
// Controller of the union-find engine: command sequencing, handshakes and
// configuration registers. Depends on ufhk_pkg.
`default_nettype none

module ufhk_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    output      logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic               i_cfg_data,
    input  wire logic [1:0]         i_cmd,
    input  wire ufhk_pkg::t_dp_stat i_dp_stat,
    output      ufhk_pkg::t_dp_cmd  o_dp_cmd
);
    import ufhk_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_WALK  = 6'b000100,
        S_COMP  = 6'b001000,
        S_LINK  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    logic    r_second, n_second;
    t_status r_status, n_status;
    logic    r_ovalid;
    logic    r_use_rank, r_use_comp;
    logic    after_walk;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_rank <= 1'b1;
            r_use_comp <= 1'b1;
        end else if (i_cfg_we) begin
            if (t_cfg_idx'(i_cfg_idx) == CFG_USE_RANK) begin
                r_use_rank <= i_cfg_data;
            end else begin
                r_use_comp <= i_cfg_data;
            end
        end
    end

    // Sequence one command through probe, walk, compress and link
    always_comb begin
        n_state           = r_state;
        n_second          = r_second;
        n_status          = r_status;
        o_dp_cmd          = '0;
        o_dp_cmd.use_rank = r_use_rank;
        o_dp_cmd.status   = r_status;
        after_walk        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_second      = 1'b0;
                    n_status      = ST_OK;
                    n_state       = (t_cmd'(i_cmd) == CMD_STEPS) ? S_RESP : S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_dp_stat.cmd == CMD_MAKE) begin
                    if (!i_dp_stat.used) begin
                        o_dp_cmd.insert = 1'b1;
                        n_state         = S_RESP;
                    end else if (i_dp_stat.hit) begin
                        n_status = ST_DUPLICATE;
                        n_state  = S_RESP;
                    end else if (i_dp_stat.probe_last) begin
                        n_status = ST_FULL;
                        n_state  = S_RESP;
                    end else begin
                        o_dp_cmd.probe_next = 1'b1;
                    end
                end else if (i_dp_stat.hit) begin
                    if ((i_dp_stat.cmd == CMD_UNION) && !r_second) begin
                        o_dp_cmd.save_a = 1'b1;
                        n_second        = 1'b1;
                    end else begin
                        o_dp_cmd.save_b     = 1'b1;
                        o_dp_cmd.walk_start = 1'b1;
                        o_dp_cmd.walk_src   = r_second ? WS_SA : WS_CUR;
                        n_second            = 1'b0;
                        n_state             = S_WALK;
                    end
                end else if (!i_dp_stat.used || i_dp_stat.probe_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_dp_cmd.probe_next = 1'b1;
                end
            end
            S_WALK: begin
                if (i_dp_stat.is_root || i_dp_stat.walk_limit) begin
                    o_dp_cmd.walk_end   = 1'b1;
                    o_dp_cmd.walk_sel_y = r_second;
                    if (r_use_comp) begin
                        o_dp_cmd.comp_start = 1'b1;
                        n_state             = S_COMP;
                    end else begin
                        after_walk = 1'b1;
                    end
                end else begin
                    o_dp_cmd.walk_step = 1'b1;
                end
            end
            S_COMP: begin
                if (i_dp_stat.at_root || i_dp_stat.walk_limit) begin
                    after_walk = 1'b1;
                end else begin
                    o_dp_cmd.comp_step = 1'b1;
                end
            end
            S_LINK: begin
                o_dp_cmd.link = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    o_dp_cmd.respond = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Finish a walk: answer a find, start the second union walk, or link
        if (after_walk) begin
            if (i_dp_stat.cmd != CMD_UNION) begin
                n_state = S_RESP;
            end else if (!r_second) begin
                o_dp_cmd.walk_start = 1'b1;
                o_dp_cmd.walk_src   = WS_SB;
                n_second            = 1'b1;
                n_state             = S_WALK;
            end else begin
                n_state = S_LINK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_status <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_status <= n_status;
            if (o_dp_cmd.respond) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

`ifndef SYNTHESIS
    a_respond_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.respond |-> (!r_ovalid || i_ready))
        else $error("result overwritten before transfer");
    a_link_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (i_dp_stat.cmd == CMD_UNION) && r_second)
        else $error("link outside second union walk");
    a_resp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.respond |=> o_valid)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

FILE: hdl/union_find_hashed_keys.sv
// Union-find engine over a hashed key table with triangular probing.
// Make/find/union probe the table, walk the parent chain (twice with
// compression), link for a union and register the result; read step count
// goes straight to the result. One command at a time: a new one is taken
// only when idle. Reset is synchronous, active low: clears used bits, step
// count and handshakes, and sets both switches.
`default_nettype none

module union_find_hashed_keys (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [ufhk_pkg::KEY_W-1:0]  i_key_a,
    input  wire logic [ufhk_pkg::KEY_W-1:0]  i_key_b,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [1:0]                  o_status,
    output      logic [ufhk_pkg::KEY_W-1:0]  o_result_key,
    output      logic [ufhk_pkg::STEP_W-1:0] o_step_total,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic                        i_cfg_data
);
    import ufhk_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Command sequencer
    ufhk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    // Slot table and result registers
    ufhk_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .o_dp_stat    (dp_stat),
        .i_cmd        (i_cmd),
        .i_key_a      (i_key_a),
        .i_key_b      (i_key_b),
        .o_status     (o_status),
        .o_result_key (o_result_key),
        .o_step_total (o_step_total)
    );

endmodule

`default_nettype wire

FILE: tb/ufhk_checker.sv
// Checker for union_find_hashed_keys: watches the command, result and config
// ports, predicts every result and compares it field by field.
// Depends on ufhk_pkg for command, status and register index codes.
`default_nettype none

module ufhk_checker
    import ufhk_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_ready_in,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [KEY_W-1:0]  i_key_a,
    input  wire logic [KEY_W-1:0]  i_key_b,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_ready,
    input  wire logic [1:0]        i_status,
    input  wire logic [KEY_W-1:0]  i_result_key,
    input  wire logic [STEP_W-1:0] i_step_total,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic              i_cfg_data,
    output      int                o_pending,
    output      int                o_errors
);

    typedef struct packed {
        t_status           status;
        logic [KEY_W-1:0]  key;
        logic [STEP_W-1:0] steps;
    } t_answer;

    // Shadow copy of the forest
    logic [KEY_W-1:0]  key_at   [TABLE_SLOTS];
    logic              occupied [TABLE_SLOTS];
    logic [SLOT_W-1:0] up_of    [TABLE_SLOTS];
    logic [RANK_W-1:0] height   [TABLE_SLOTS];
    logic [STEP_W-1:0] visit_count;
    logic              by_rank;
    logic              compress;
    t_answer           answers_due[$];
    int                errors;

    assign o_errors  = errors;

    function automatic logic [SLOT_W-1:0] probe_slot(logic [KEY_W-1:0] k, int i);
        return SLOT_W'(k % TABLE_SLOTS + (i * (i + 1)) / 2);
    endfunction

    // Return the slot holding k, or -1 when absent
    function automatic int locate(logic [KEY_W-1:0] k);
        logic [SLOT_W-1:0] p;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            p = probe_slot(k, i);
            if (!occupied[p]) return -1;
            if (key_at[p] == k) return int'(p);
        end
        return -1;
    endfunction

    // Walk to the root, counting visited nodes, then flatten the path when compression is on
    function automatic logic [SLOT_W-1:0] root_of(logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r, cur, nxt;
        int n;
        r = s;
        n = 0;
        visit_count++;
        while (up_of[r] != r && n < TABLE_SLOTS) begin
            r = up_of[r];
            visit_count++;
            n++;
        end
        if (compress) begin
            cur = s;
            n = 0;
            while (cur != r && n < TABLE_SLOTS) begin
                nxt = up_of[cur];
                up_of[cur] = r;
                cur = nxt;
                n++;
            end
        end
        return r;
    endfunction

    function automatic t_answer predict(t_cmd c, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
        t_answer ans;
        logic [SLOT_W-1:0] p, rx, ry;
        int sa, sb;
        ans.status = ST_OK;
        ans.key    = '0;
        case (c)
            CMD_MAKE: begin
                ans.status = ST_FULL;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    p = probe_slot(ka, i);
                    if (!occupied[p]) begin
                        occupied[p] = 1'b1;
                        key_at[p]   = ka;
                        up_of[p]    = p;
                        height[p]   = '0;
                        ans.status  = ST_OK;
                        ans.key     = ka;
                        break;
                    end
                    if (key_at[p] == ka) begin
                        ans.status = ST_DUPLICATE;
                        break;
                    end
                end
            end
            CMD_UNION: begin
                sa = locate(ka);
                sb = locate(kb);
                if (sa < 0 || sb < 0) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    rx = root_of(SLOT_W'(sa));
                    ry = root_of(SLOT_W'(sb));
                    if (rx == ry) begin
                        ans.key = key_at[rx];
                    end else if (by_rank && height[rx] < height[ry]) begin
                        up_of[rx] = ry;
                        ans.key   = key_at[ry];
                    end else begin
                        up_of[ry] = rx;
                        ans.key   = key_at[rx];
                        if (by_rank && height[rx] == height[ry] && height[rx] < RANK_MAX)
                            height[rx]++;
                    end
                end
            end
            CMD_FIND: begin
                sa = locate(ka);
                if (sa < 0) ans.status = ST_NOT_FOUND;
                else        ans.key = key_at[root_of(SLOT_W'(sa))];
            end
            default: ;
        endcase
        ans.steps = visit_count;
        return ans;
    endfunction

    // Predict on command transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) occupied[i] = 1'b0;
            visit_count = '0;
            by_rank     = 1'b1;
            compress    = 1'b1;
            answers_due.delete();
            if (errors < 0) errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_USE_RANK) by_rank  = i_cfg_data;
                else                           compress = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d key %0d steps %0d",
                             $time, i_status, i_result_key, i_step_total);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status || i_result_key !== want.key ||
                        i_step_total !== want.steps) begin
                        $display("%0t: mismatch expected status %0d key %0d steps %0d, got %0d %0d %0d",
                                 $time, want.status, want.key, want.steps,
                                 i_status, i_result_key, i_step_total);
                        errors++;
                    end
                end
            end
            if (i_valid && i_ready_in)
                answers_due.push_back(predict(t_cmd'(i_cmd), i_key_a, i_key_b));
        end
        o_pending = answers_due.size();
    end

    initial begin
        errors    = 0;
        o_pending = 0;
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Top of the union_find_hashed_keys testbench: clock, reset, stimulus and verdict.
// Depends on ufhk_pkg, the union_find_hashed_keys block and ufhk_checker.
`default_nettype none

module tb;
    import ufhk_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 275;

    logic              i_clk;
    logic              i_rst_n;
    logic              cmd_valid, cmd_ready;
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key_a, key_b;
    logic              res_valid, res_ready;
    logic [1:0]        status;
    logic [KEY_W-1:0]  result_key;
    logic [STEP_W-1:0] step_total;
    logic              cfg_we, cfg_idx, cfg_data;
    int                pending, errors;
    int                cycle;
    int                quiet_cycles;
    logic              sender_calm;
    logic [KEY_W-1:0]  key_pool[64];

    union_find_hashed_keys dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(cmd_valid), .o_ready(cmd_ready),
        .i_cmd(cmd), .i_key_a(key_a), .i_key_b(key_b),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_status(status), .o_result_key(result_key), .o_step_total(step_total),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    ufhk_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(cmd_valid), .i_ready_in(cmd_ready),
        .i_cmd(cmd), .i_key_a(key_a), .i_key_b(key_b),
        .i_res_valid(res_valid), .i_res_ready(res_ready),
        .i_status(status), .i_result_key(result_key), .i_step_total(step_total),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, one long hold-off, one stretch always ready
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= 3000 && cycle < 3400)       res_ready <= 1'b0;
        else if (cycle >= 8000 && cycle < 20000) res_ready <= 1'b1;
        else res_ready <= ($urandom_range(0, 99) >= 7);
    end

    // Watchdog: end the run if nothing transfers for too long
    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one command and hold it until the transfer
    task automatic send(t_cmd c, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
        if (!sender_calm && $urandom_range(0, 99) < 7) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        key_a     <= ka;
        key_b     <= kb;
        @(negedge i_clk);
        while (!cmd_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Drain all results, then write a register while idle
    task automatic write_reg(t_cfg_idx idx, logic val);
        cmd_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
        return key_pool[$urandom_range(0, 63)];
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)      send(CMD_MAKE, pick_key(), KEY_W'($urandom));
        else if (r < 60) send(CMD_UNION, pick_key(), pick_key());
        else if (r < 90) send(CMD_FIND, pick_key(), KEY_W'($urandom));
        else             send(CMD_STEPS, KEY_W'($urandom), KEY_W'($urandom));
    endtask

    initial begin
        logic [KEY_W-1:0] top_key;
        logic             rank_set[5];
        logic             comp_set[5];
        rank_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        comp_set = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        top_key = {KEY_W{1'b1}};
        cycle = 0;
        quiet_cycles = 0;
        sender_calm = 1'b0;
        i_rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = CMD_STEPS;
        key_a = '0;
        key_b = '0;
        res_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_USE_RANK;
        cfg_data = 1'b0;
        // Pool keys share few low bytes so probe chains collide
        for (int i = 0; i < 64; i++)
            key_pool[i] = {(KEY_W-8)'($urandom), 8'($urandom_range(0, 11) * 23)};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, collisions, duplicates, equal roots
        send(CMD_STEPS, top_key, top_key);
        send(CMD_FIND, 0, 0);
        send(CMD_UNION, 0, top_key);
        send(CMD_MAKE, 0, top_key);
        send(CMD_MAKE, top_key, 0);
        send(CMD_MAKE, 0, 0);
        send(CMD_MAKE, 256, 0);
        send(CMD_MAKE, 512, 0);
        send(CMD_MAKE, 1 << 30, 0);
        send(CMD_UNION, 256, 0);
        send(CMD_UNION, 0, 256);
        send(CMD_UNION, 512, top_key);
        send(CMD_UNION, 0, 512);
        send(CMD_UNION, 256, top_key);
        send(CMD_FIND, top_key, 0);
        send(CMD_FIND, 768, 0);
        send(CMD_UNION, 1 << 30, 768);
        send(CMD_UNION, 1 << 30, 0);
        send(CMD_FIND, 1 << 30, 0);
        send(CMD_STEPS, 0, 0);

        // Random phases across all register settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_USE_RANK, rank_set[ph]);
            write_reg(CFG_USE_COMP, comp_set[ph]);
            sender_calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
        end
        sender_calm = 1'b0;

        // Fill the table, then probe it while full
        for (int n = 0; n < 240; n++) send(CMD_MAKE, KEY_W'($urandom), 0);
        for (int n = 0; n < 20; n++) random_item();
        for (int n = 0; n < 4; n++) send(CMD_MAKE, KEY_W'($urandom), 0);

        // Drain and give the verdict
        cmd_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
